>>> hw/rtl/msc_pkg.sv
// ----------------------------------------------------------------------------
// msc_pkg
// Shared types and character constants for the motor speed command parser.
// ----------------------------------------------------------------------------
package msc_pkg;

    // result event codes
    typedef enum logic [2:0] {
        EV_TARGET  = 3'd0,
        EV_BRAKE   = 3'd1,
        EV_COAST   = 3'd2,
        EV_UNKNOWN = 3'd3,
        EV_IGNORED = 3'd4
    } t_event;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_B_UP  = 8'h42;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_C_UP  = 8'h43;
    localparam logic [7:0] CH_C_LO  = 8'h63;
    localparam logic [7:0] CH_T_UP  = 8'h54;
    localparam logic [7:0] CH_T_LO  = 8'h74;

    localparam int          ACC_W       = 14;
    localparam int          RPM_W       = 15;
    localparam logic [16:0] VALUE_LIMIT = 17'd9999;

    // summary of the current line, handed from the line buffer to the decoder
    typedef struct packed {
        logic              len_zero;
        logic              len_one;
        logic              len_two;
        logic              minus;
        logic              invalid;
        logic [7:0]        first;
        logic [ACC_W-1:0]  acc;
    } t_line_info;

endpackage

>>> hw/rtl/msc_line_acc.sv
// ----------------------------------------------------------------------------
// msc_line_acc
// Line state: length, first character, sign and running decimal value.
// ----------------------------------------------------------------------------
module msc_line_acc
    import msc_pkg::*;
#(
    parameter int LINE_MAX = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,     // non-terminator character to keep
    input  logic       i_clear,    // line decoded, start a new one
    input  logic [7:0] i_char,
    output t_line_info o_info
);

    localparam int LEN_W = $clog2(LINE_MAX);

    logic [LEN_W-1:0] r_len,   n_len;
    logic [7:0]       r_first, n_first;
    logic             r_minus, n_minus;
    logic [ACC_W-1:0] r_acc,   n_acc;
    logic             r_inv,   n_inv;

    logic             is_digit;
    logic [16:0]      acc_next;

    assign is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    // acc * 10 + digit as two shifts and adds
    assign acc_next = {r_acc, 3'b000} + {2'b00, r_acc, 1'b0}
                    + {13'd0, i_char[3:0]};

    always_comb begin
        n_len   = r_len;
        n_first = r_first;
        n_minus = r_minus;
        n_acc   = r_acc;
        n_inv   = r_inv;
        if (i_clear) begin
            n_len = '0;
        end else if (i_take && (r_len != LEN_W'(LINE_MAX - 1))) begin
            n_len = r_len + 1'b1;
            if (r_len == '0) begin
                n_first = i_char;
                n_minus = 1'b0;
                n_acc   = '0;
                n_inv   = 1'b0;
            end else if ((r_len == LEN_W'(1)) && (i_char == CH_MINUS)) begin
                n_minus = 1'b1;
            end else if (!is_digit) begin
                n_inv = 1'b1;
            end else if (!r_inv) begin
                if (acc_next > VALUE_LIMIT) begin
                    n_inv = 1'b1;
                end else begin
                    n_acc = acc_next[ACC_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_first <= '0;
            r_minus <= 1'b0;
            r_acc   <= '0;
            r_inv   <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_first <= n_first;
            r_minus <= n_minus;
            r_acc   <= n_acc;
            r_inv   <= n_inv;
        end
    end

    always_comb begin
        o_info          = '0;
        o_info.len_zero = (r_len == '0);
        o_info.len_one  = (r_len == LEN_W'(1));
        o_info.len_two  = (r_len == LEN_W'(2));
        o_info.minus    = r_minus;
        o_info.invalid  = r_inv;
        o_info.first    = r_first;
        o_info.acc      = r_acc;
    end

    a_acc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= ACC_W'(9999))
        else $error("accumulated value out of range");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |=> r_len == '0)
        else $error("line not emptied after decode");

    a_minus_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_minus && !o_info.len_zero |-> !o_info.len_one)
        else $error("minus flag on a one-character line");

endmodule

>>> hw/rtl/msc_decode.sv
// ----------------------------------------------------------------------------
// msc_decode
// Decodes a finished line and holds the motor target, loop and stop mode.
// ----------------------------------------------------------------------------
module msc_decode
    import msc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,      // terminator on a non-empty line
    input  t_line_info       i_info,
    output t_event           o_event,
    output logic [RPM_W-1:0] o_target,    // values after this line
    output logic             o_loop,
    output logic             o_coast
);

    logic [RPM_W-1:0] r_target, n_target;
    logic             r_loop,   n_loop;
    logic             r_coast,  n_coast;
    logic             is_b, is_c, is_t, no_digits;
    logic [RPM_W-1:0] mag;

    assign is_b      = (i_info.first == CH_B_UP) || (i_info.first == CH_B_LO);
    assign is_c      = (i_info.first == CH_C_UP) || (i_info.first == CH_C_LO);
    assign is_t      = (i_info.first == CH_T_UP) || (i_info.first == CH_T_LO);
    assign no_digits = i_info.len_one || (i_info.len_two && i_info.minus);
    assign mag       = {1'b0, i_info.acc};

    always_comb begin
        o_event  = EV_UNKNOWN;
        n_target = r_target;
        n_loop   = r_loop;
        n_coast  = r_coast;
        if (i_info.len_one && is_b) begin
            o_event  = EV_BRAKE;
            n_target = '0;
            n_loop   = 1'b0;
            n_coast  = 1'b0;
        end else if (i_info.len_one && is_c) begin
            o_event  = EV_COAST;
            n_target = '0;
            n_loop   = 1'b0;
            n_coast  = 1'b1;
        end else if (is_t) begin
            if (no_digits || i_info.invalid) begin
                o_event = EV_IGNORED;
            end else if (i_info.acc == '0) begin
                o_event  = EV_BRAKE;
                n_target = '0;
                n_loop   = 1'b0;
                n_coast  = 1'b0;
            end else begin
                o_event  = EV_TARGET;
                n_target = i_info.minus ? (~mag + 1'b1) : mag;
                n_loop   = 1'b1;
            end
        end
    end

    assign o_target = n_target;
    assign o_loop   = n_loop;
    assign o_coast  = n_coast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
            r_loop   <= 1'b0;
            r_coast  <= 1'b0;
        end else if (i_fire) begin
            r_target <= n_target;
            r_loop   <= n_loop;
            r_coast  <= n_coast;
        end
    end

    a_loop_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loop == (r_target != '0))
        else $error("loop state and target disagree");

endmodule

>>> hw/rtl/motor_speed_command_parser.sv
// ----------------------------------------------------------------------------
// motor_speed_command_parser
// Line parser for serial motor speed commands (B, C, T[-]digits).
// ----------------------------------------------------------------------------
// usage
//   input channel: one received byte per request on i_rx_char, qualified by
//   i_valid and held off by o_stall. cr or lf ends a line; empty lines and
//   plain characters produce no result
//   output channel: one request per non-empty line, fields o_event_res,
//   o_target_rpm, o_closed_loop, o_coast_stop, o_lead_char, qualified by
//   o_valid and held off by i_stall
//   path: a terminator is captured in the input register, decoded from there
//   and written to the result register, which drives o_valid; a held result
//   keeps the terminator waiting in the input register
//   throughput: one byte per cycle while no terminator waits on a held
//   result, set by the single decode pass from input to result register
//   stall: a held result keeps its fields; bytes that produce no result still
//   flow past it; a terminator on a non-empty line waits and o_stall rises
//   reset: synchronous, active low; line empty, target 0, loop off, brake mode
// ----------------------------------------------------------------------------
module motor_speed_command_parser
    import msc_pkg::*;
#(
    parameter int LINE_MAX = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_char,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_event_res,
    output logic signed [14:0] o_target_rpm,
    output logic              o_closed_loop,
    output logic              o_coast_stop,
    output logic [7:0]        o_lead_char
);

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_char;

    // result register
    logic             r_out_valid;
    logic [2:0]       r_ev;
    logic [RPM_W-1:0] r_tgt;
    logic             r_loop;
    logic             r_coast;
    logic [7:0]       r_lead;

    t_line_info       line_info;
    t_event           dec_event;
    logic [RPM_W-1:0] dec_target;
    logic             dec_loop;
    logic             dec_coast;

    logic             is_eol, emits, blocked, advance, take, fire, out_free;

    assign is_eol   = (r_in_char == CH_CR) || (r_in_char == CH_LF);
    // terminator on a kept line produces a result
    assign emits    = is_eol && !line_info.len_zero;
    assign out_free = !r_out_valid || !i_stall;
    assign blocked  = r_in_valid && emits && !out_free;
    assign advance  = r_in_valid && !blocked;
    assign take     = advance && !is_eol;
    assign fire     = advance && emits;
    assign o_stall  = blocked;

    msc_line_acc #(
        .LINE_MAX (LINE_MAX)
    ) u_line (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_clear (fire),
        .i_char  (r_in_char),
        .o_info  (line_info)
    );

    msc_decode u_dec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_info   (line_info),
        .o_event  (dec_event),
        .o_target (dec_target),
        .o_loop   (dec_loop),
        .o_coast  (dec_coast)
    );

    // input register: reloads whenever the held byte moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!blocked) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !blocked) begin
            r_in_char <= i_rx_char;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ev    <= dec_event;
            r_tgt   <= dec_target;
            r_loop  <= dec_loop;
            r_coast <= dec_coast;
            r_lead  <= line_info.first;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_event_res   = r_ev;
    assign o_target_rpm  = r_tgt;
    assign o_closed_loop = r_loop;
    assign o_coast_stop  = r_coast;
    assign o_lead_char   = r_lead;

    // only a terminator waiting on a full result register holds the input
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled without a held result");

    // a new result never overwrites one still held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> !r_out_valid || !i_stall)
        else $error("result overwritten while stalled");

    // brake result always leaves brake mode with the loop off
    a_brake_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == EV_BRAKE) |-> !o_coast_stop && !o_closed_loop
            && (o_target_rpm == '0))
        else $error("brake result with inconsistent state");

    // coast result selects coast mode
    a_coast_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_res == EV_COAST) |-> o_coast_stop && !o_closed_loop)
        else $error("coast result with inconsistent state");

    // loop off means zero target
    a_idle_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_closed_loop |-> o_target_rpm == '0)
        else $error("nonzero target with loop off");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the motor speed command parser: characters are
// streamed in as single requests, every decoded line is predicted by a
// cycle-free model of the parser and compared field by field.
// ----------------------------------------------------------------------------

import msc_pkg::*;

// one decoded line as it appears on the output channel
typedef struct packed {
    t_event                  ev;
    logic signed [RPM_W-1:0] rpm;
    logic                    loop_on;
    logic                    coast;
    logic [7:0]              lead;
} t_cmd_result;

class cmd_scoreboard;
    // parser state as the bench sees it
    int                      keep_max;
    logic [3:0]              line_len;
    logic [7:0]              lead;
    logic                    neg;
    logic [ACC_W-1:0]        value;
    logic                    bad;
    logic signed [RPM_W-1:0] rpm;
    logic                    loop_on;
    logic                    coast;

    t_cmd_result pending_q[$];
    int          mismatches;
    int          results_checked;
    int          ev_count[5];

    function new(int kept);
        keep_max = kept;
        line_len = '0;
        lead     = '0;
        neg      = 1'b0;
        value    = '0;
        bad      = 1'b0;
        rpm      = '0;
        loop_on  = 1'b0;
        coast    = 1'b0;
    endfunction

    function void stop_motor(logic to_coast);
        loop_on = 1'b0;
        rpm     = '0;
        coast   = to_coast;
    endfunction

    // one accepted character request; a terminator on a non-empty line queues a result
    function void note_char(logic [7:0] c);
        t_cmd_result r;
        t_event      ev;
        int          next;
        int          digits;
        int          v;
        if (c != CH_CR && c != CH_LF) begin
            if (int'(line_len) >= keep_max)
                return;
            line_len = line_len + 4'd1;
            if (line_len == 4'd1) begin
                lead  = c;
                neg   = 1'b0;
                value = '0;
                bad   = 1'b0;
            end else if (line_len == 4'd2 && c == CH_MINUS) begin
                neg = 1'b1;
            end else if (c < CH_ZERO || c > CH_NINE) begin
                bad = 1'b1;
            end else if (!bad) begin
                next = int'(value) * 10 + int'(c - CH_ZERO);
                if (next > int'(VALUE_LIMIT))
                    bad = 1'b1;
                else
                    value = ACC_W'(next);
            end
            return;
        end
        if (line_len == 4'd0)
            return;
        if (line_len == 4'd1 && (lead == CH_B_UP || lead == CH_B_LO)) begin
            stop_motor(1'b0);
            ev = EV_BRAKE;
        end else if (line_len == 4'd1 && (lead == CH_C_UP || lead == CH_C_LO)) begin
            stop_motor(1'b1);
            ev = EV_COAST;
        end else if (lead == CH_T_UP || lead == CH_T_LO) begin
            digits = int'(line_len) - 1 - int'(neg);
            if (line_len < 4'd2 || digits == 0 || bad) begin
                ev = EV_IGNORED;
            end else if (value == '0) begin
                stop_motor(1'b0);
                ev = EV_BRAKE;
            end else begin
                v       = neg ? -int'(value) : int'(value);
                rpm     = v[RPM_W-1:0];
                loop_on = 1'b1;
                ev      = EV_TARGET;
            end
        end else begin
            ev = EV_UNKNOWN;
        end
        r = '{ev, rpm, loop_on, coast, lead};
        pending_q.push_back(r);
        ev_count[int'(ev)]++;
        line_len = '0;
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 20)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_result(t_cmd_result got);
        t_cmd_result want;
        results_checked++;
        if (pending_q.size() == 0) begin
            report($sformatf("result %0d arrived with no line pending", results_checked));
            return;
        end
        want = pending_q.pop_front();
        if (got.ev != want.ev)
            report($sformatf("result %0d event %0d, expected %0d",
                             results_checked, got.ev, want.ev));
        if (got.rpm != want.rpm)
            report($sformatf("result %0d target %0d, expected %0d",
                             results_checked, got.rpm, want.rpm));
        if (got.loop_on != want.loop_on)
            report($sformatf("result %0d closed loop %0b, expected %0b",
                             results_checked, got.loop_on, want.loop_on));
        if (got.coast != want.coast)
            report($sformatf("result %0d coast mode %0b, expected %0b",
                             results_checked, got.coast, want.coast));
        if (got.lead != want.lead)
            report($sformatf("result %0d lead char %02h, expected %02h",
                             results_checked, got.lead, want.lead));
    endtask

    function int outstanding();
        return pending_q.size();
    endfunction
endclass

module tb;

    localparam int LINE_MAX    = 16;
    localparam int HOLD_CYCLES = 300;   // long receiver hold-off for the pressure part
    localparam int STUCK_LIMIT = 2000;  // cycles with no request moving on either side

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [7:0]              i_rx_char;
    logic                    o_valid;
    logic                    i_stall;
    logic [2:0]              o_event_res;
    logic signed [RPM_W-1:0] o_target_rpm;
    logic                    o_closed_loop;
    logic                    o_coast_stop;
    logic [7:0]              o_lead_char;

    cmd_scoreboard sb;

    int   idle_pct;        // sender gap chance, percent
    int   stall_pct = 0;   // receiver stall chance, percent
    logic hold_req  = 1'b0;
    logic hold_seen;
    int   hold_left;
    int   chars_sent;
    int   stuck_cycles;
    int   input_stalls;

    motor_speed_command_parser #(
        .LINE_MAX(LINE_MAX)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rx_char    (i_rx_char),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_event_res  (o_event_res),
        .o_target_rpm (o_target_rpm),
        .o_closed_loop(o_closed_loop),
        .o_coast_stop (o_coast_stop),
        .o_lead_char  (o_lead_char)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver side: random stalls, or a long hold-off whenever hold_req toggles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_seen <= 1'b0;
            hold_left <= 0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES - 1;
            i_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitors and watchdog; all values read here are the ones before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_result('{t_event'(o_event_res), o_target_rpm, o_closed_loop,
                                  o_coast_stop, o_lead_char});
            if (i_valid && !o_stall)
                sb.note_char(i_rx_char);
            if (i_valid && o_stall)
                input_stalls++;
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                stuck_cycles <= 0;
            end else if (stuck_cycles >= STUCK_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", STUCK_LIMIT);
                $display("status: fail");
                $finish;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
        end
    end

    function automatic logic [7:0] any_byte();
        logic [7:0] c;
        // anything but a line terminator
        do
            c = 8'($urandom_range(255));
        while (c == CH_CR || c == CH_LF);
        return c;
    endfunction

    // offer one character request and hold it until taken
    task automatic send_char(input logic [7:0] c);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_char <= c;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text(input string s, input logic [7:0] term);
        for (int k = 0; k < s.len(); k++)
            send_char(8'(s[k]));
        send_char(term);
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic drain();
        i_valid <= 1'b0;
        // let the monitor note the last accepted character first
        @(posedge i_clk);
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // mostly well-formed commands with random content, the rest broken or noise
    task automatic send_random_line();
        logic [7:0] q[$];
        logic [7:0] c;
        int         kind;
        int         n;
        int         pos;
        logic       all_zero;
        kind = $urandom_range(99);
        if (kind < 12) begin
            // stop commands, now and then with a trailing character
            case ($urandom_range(3))
                0: c = CH_B_UP;
                1: c = CH_B_LO;
                2: c = CH_C_UP;
                default: c = CH_C_LO;
            endcase
            q.push_back(c);
            if ($urandom_range(4) == 0)
                q.push_back(any_byte());
        end else if (kind < 67) begin
            // speed target, sometimes too large, zero or corrupted
            q.push_back($urandom_range(1) ? CH_T_UP : CH_T_LO);
            if ($urandom_range(1))
                q.push_back(CH_MINUS);
            n        = ($urandom_range(9) == 0) ? 5 : $urandom_range(4, 1);
            all_zero = ($urandom_range(19) == 0);
            repeat (n)
                q.push_back(all_zero ? CH_ZERO : 8'(CH_ZERO + $urandom_range(9)));
            if (kind >= 55) begin
                pos = $urandom_range(q.size(), 1);
                c   = ($urandom_range(2) == 0) ? CH_MINUS : any_byte();
                q.insert(pos, c);
            end
        end else if (kind < 82) begin
            // line noise
            n = $urandom_range(6, 1);
            repeat (n)
                q.push_back(any_byte());
        end else if (kind < 92) begin
            // overlong target line: the tail past the kept length must be dropped
            q.push_back($urandom_range(1) ? CH_T_UP : CH_T_LO);
            repeat (LINE_MAX - 2)
                q.push_back(($urandom_range(99) < 85) ? CH_ZERO
                                                      : 8'(CH_ZERO + $urandom_range(9)));
            n = $urandom_range(6);
            repeat (n)
                q.push_back(($urandom_range(1) == 0) ? any_byte()
                                                     : 8'(CH_ZERO + $urandom_range(9)));
        end
        // anything else is an empty line
        foreach (q[k])
            send_char(q[k]);
        send_char($urandom_range(1) ? CH_CR : CH_LF);
        if ($urandom_range(6) == 0)
            send_char(CH_LF);
    endtask

    int idle_set[4]  = '{0, 58, 0, 9};
    int stall_set[4] = '{0, 0, 58, 9};
    int goal;

    initial begin
        sb           = new(LINE_MAX - 1);
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_rx_char    = 8'h00;
        i_stall      = 1'b0;
        idle_pct     = 0;
        chars_sent   = 0;
        stuck_cycles = 0;
        input_stalls = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: both stop modes, range ends, zero, missing digits, empty,
        // oversize value and unknown lines with extreme bytes
        send_text("b", CH_CR);
        send_text("C", CH_LF);
        send_text("T9999", CH_CR);
        send_text("t-1", CH_LF);
        send_text("T-0", CH_CR);
        send_text("T", CH_LF);
        send_text("t-", CH_CR);
        send_char(CH_CR);
        send_text("T10000", CH_CR);
        send_char(8'hFF);
        send_char(CH_LF);
        send_char(8'h00);
        send_char(CH_CR);
        drain();

        // pressure: receiver holds off while lines keep coming, input must back up
        hold_req <= ~hold_req;
        repeat (40) send_random_line();
        drain();

        // random phases with different idling on each side
        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_set[p];
            stall_pct <= stall_set[p];
            goal      = chars_sent + 370;
            while (chars_sent < goal)
                send_random_line();
            drain();
        end
        stall_pct <= 0;
        drain();

        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));
        $display("covered %0d characters and %0d decoded lines,",
                 chars_sent, sb.results_checked);
        $display("%0d cycles of input back-pressure", input_stalls);
        $display("lines by outcome: target %0d brake %0d coast %0d unknown %0d ignored %0d",
                 sb.ev_count[0], sb.ev_count[1], sb.ev_count[2], sb.ev_count[3],
                 sb.ev_count[4]);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
